FILE: rtl/mfc_pkg.sv
package mfc_pkg;

	// Fixed field widths of the correlator interface
	localparam int unsigned SUM_W       = 38;
	localparam int unsigned TAP_COUNT_W = 7;
	localparam int unsigned TAP_INDEX_W = 6;

	localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RESET = 7'd64;

	// Item function codes
	localparam logic FUNC_LOAD   = 1'b0;
	localparam logic FUNC_SAMPLE = 1'b1;

	// Per-cell control: tap write, tap ring rotate, sample ring rotate/push
	typedef struct packed {
		logic tap_wr;
		logic tap_shift;
		logic samp_shift;
	} cell_ctl_t;

endpackage

FILE: rtl/mfc_cell.sv
module mfc_cell #(
	parameter int unsigned W = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  mfc_pkg::cell_ctl_t  ctl,
	input  logic signed [W-1:0] wr_data,
	input  logic signed [W-1:0] tap_nxt,
	input  logic signed [W-1:0] samp_nxt,
	output logic signed [W-1:0] tap,
	output logic signed [W-1:0] samp
);

	logic signed [W-1:0] tap_q;
	logic signed [W-1:0] samp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_q  <= '0;
			samp_q <= '0;
		end else begin
			if (ctl.tap_wr) begin
				tap_q <= wr_data;
			end else if (ctl.tap_shift) begin
				tap_q <= tap_nxt;
			end
			if (ctl.samp_shift) begin
				samp_q <= samp_nxt;
			end
		end
	end

	assign tap  = tap_q;
	assign samp = samp_q;

endmodule

FILE: rtl/mfc_mac.sv
module mfc_mac #(
	parameter int unsigned W = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              clear,
	input  logic                              en,
	input  logic signed [W-1:0]               tap,
	input  logic signed [W-1:0]               samp,
	output logic signed [mfc_pkg::SUM_W-1:0]  acc,
	output logic                              busy
);

	localparam int unsigned PROD_W = 2 * W;

	logic signed [PROD_W-1:0]         prod_s1;
	logic                             prod_v_s1;
	logic signed [mfc_pkg::SUM_W-1:0] acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_v_s1 <= 1'b0;
		end else begin
			prod_v_s1 <= en;
		end
	end

	// Product register, then a wrapping add into the sum
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= tap * samp;
		end
		if (clear) begin
			acc_q <= '0;
		end else if (prod_v_s1) begin
			acc_q <= acc_q + mfc_pkg::SUM_W'(prod_s1);
		end
	end

	assign acc  = acc_q;
	assign busy = prod_v_s1;

endmodule

FILE: rtl/matched_filter_correlator.sv
// Channel   Handshake                   Payload
// in        in_valid / in_ready         func, tap_index, value
// out       out_valid / out_ready       correlation_sum
// cfg       cfg_wr_en (no wait)         cfg_wr_data -> tap_count
//
// A tap load, or a sample that does not complete the window, is taken in idle and leaves
// the block in idle. A sample with a result runs push, align the sample ring (skipped
// when K = NUM_TAPS; K = window length), the MAC sweep over K taps, rotate the tap
// ring home, then hand off to a free output register. in_ready is high only in idle.
// Reset clears taps, samples and the fill count. A waiting result holds in the output
// register while the next item is taken; a later one holds in the accumulator until it frees.
module matched_filter_correlator #(
	parameter int unsigned NUM_TAPS     = 64,
	parameter int unsigned SAMPLE_WIDTH = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic                                   func,
	input  logic [mfc_pkg::TAP_INDEX_W-1:0]        tap_index,
	input  logic signed [SAMPLE_WIDTH-1:0]         value,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [mfc_pkg::SUM_W-1:0]       correlation_sum,
	input  logic                                   cfg_wr_en,
	input  logic [mfc_pkg::TAP_COUNT_W-1:0]        cfg_wr_data
);

	localparam int unsigned KW = $clog2(NUM_TAPS + 1);
	localparam int unsigned CW = (KW > mfc_pkg::TAP_COUNT_W) ? KW : mfc_pkg::TAP_COUNT_W;
	localparam int unsigned IDX_SPAN = 1 << mfc_pkg::TAP_INDEX_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ALIGN,
		ST_MAC,
		ST_FINISH
	} state_t;

	state_t                                state_q;
	logic [KW-1:0]                         cnt_q;
	logic [KW-1:0]                         fill_q;
	logic [mfc_pkg::TAP_COUNT_W-1:0]       tap_count_q;
	logic                                  out_valid_q;
	logic signed [mfc_pkg::SUM_W-1:0]      correlation_sum_q;

	logic signed [SAMPLE_WIDTH-1:0] tap_w  [NUM_TAPS];
	logic signed [SAMPLE_WIDTH-1:0] samp_w [NUM_TAPS];
	mfc_pkg::cell_ctl_t             ctl_w  [NUM_TAPS];

	logic                             accept;
	logic                             load_en;
	logic                             push;
	logic                             samp_shift;
	logic                             tap_shift;
	logic [CW-1:0]                    tc_ext;
	logic [CW-1:0]                    tc_clamp;
	logic [KW-1:0]                    k;
	logic [KW-1:0]                    rem;
	logic [KW-1:0]                    fill_inc;
	logic                             due;
	logic                             out_free;
	logic                             handoff;
	logic                             mac_busy;
	logic signed [mfc_pkg::SUM_W-1:0] acc;

	// Window length: zero acts as one, anything past the cell count saturates
	always_comb begin
		tc_ext = CW'(tap_count_q);
		if (tc_ext == '0) begin
			tc_clamp = CW'(1);
		end else if (tc_ext > CW'(NUM_TAPS)) begin
			tc_clamp = CW'(NUM_TAPS);
		end else begin
			tc_clamp = tc_ext;
		end
	end

	assign k   = KW'(tc_clamp);
	assign rem = KW'(NUM_TAPS) - k;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign load_en  = accept && (func == mfc_pkg::FUNC_LOAD);
	assign push     = accept && (func == mfc_pkg::FUNC_SAMPLE);

	// Fill count saturates at the window length; a lowered length resumes at once
	assign fill_inc = (fill_q < k) ? fill_q + KW'(1) : fill_q;
	assign due      = (fill_inc >= k);

	// Sample ring moves on a push and during alignment and the MAC sweep;
	// the tap ring moves during the sweep and while rotating back home.
	assign samp_shift = push || (state_q == ST_ALIGN) || (state_q == ST_MAC);
	assign tap_shift  = (state_q == ST_MAC) || ((state_q == ST_FINISH) && (cnt_q != '0));

	assign out_free = !out_valid_q || out_ready;

	// Hand the finished sum to the output register once taps are home and the
	// product stage has drained, provided the output register is free
	assign handoff = (state_q == ST_FINISH) && (cnt_q == '0) && !mac_busy && out_free;

	// Cell row. At rest cell i holds the sample pushed NUM_TAPS-1-i samples ago and
	// tap i. Both rings rotate toward cell 0; cell 0 feeds the MAC.
	for (genvar j = 0; j < NUM_TAPS; j++) begin : g_cell
		logic signed [SAMPLE_WIDTH-1:0] tap_nxt;
		logic signed [SAMPLE_WIDTH-1:0] samp_nxt;

		if (j == NUM_TAPS - 1) begin : g_tail
			assign tap_nxt  = tap_w[0];
			assign samp_nxt = push ? value : samp_w[0];
		end else begin : g_body
			assign tap_nxt  = tap_w[j+1];
			assign samp_nxt = samp_w[j+1];
		end

		if (j < IDX_SPAN) begin : g_wr
			assign ctl_w[j].tap_wr = load_en && (tap_index == mfc_pkg::TAP_INDEX_W'(j));
		end else begin : g_nowr
			assign ctl_w[j].tap_wr = 1'b0;
		end
		assign ctl_w[j].tap_shift  = tap_shift;
		assign ctl_w[j].samp_shift = samp_shift;

		mfc_cell #(
			.W (SAMPLE_WIDTH)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl_w[j]),
			.wr_data  (value),
			.tap_nxt  (tap_nxt),
			.samp_nxt (samp_nxt),
			.tap      (tap_w[j]),
			.samp     (samp_w[j])
		);
	end

	mfc_mac #(
		.W (SAMPLE_WIDTH)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (push),
		.en     (state_q == ST_MAC),
		.tap    (tap_w[0]),
		.samp   (samp_w[0]),
		.acc    (acc),
		.busy   (mac_busy)
	);

	// Sequencer, fill count, window register and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= ST_IDLE;
			cnt_q             <= '0;
			fill_q            <= '0;
			tap_count_q       <= mfc_pkg::TAP_COUNT_RESET;
			out_valid_q       <= 1'b0;
			correlation_sum_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				tap_count_q <= cfg_wr_data;
			end
			if (handoff) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (push) begin
						fill_q <= fill_inc;
						if (due) begin
							// Line the sample for tap 0 up at cell 0
							if (rem == '0) begin
								state_q <= ST_MAC;
								cnt_q   <= k;
							end else begin
								state_q <= ST_ALIGN;
								cnt_q   <= rem;
							end
						end
					end
				end
				ST_ALIGN: begin
					if (cnt_q == KW'(1)) begin
						state_q <= ST_MAC;
						cnt_q   <= k;
					end else begin
						cnt_q <= cnt_q - KW'(1);
					end
				end
				ST_MAC: begin
					if (cnt_q == KW'(1)) begin
						state_q <= ST_FINISH;
						cnt_q   <= rem;
					end else begin
						cnt_q <= cnt_q - KW'(1);
					end
				end
				ST_FINISH: begin
					// Rotate taps home, drain the product stage, then hand off
					if (cnt_q != '0) begin
						cnt_q <= cnt_q - KW'(1);
					end else if (handoff) begin
						correlation_sum_q <= acc;
						state_q           <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid       = out_valid_q;
	assign correlation_sum = correlation_sum_q;

endmodule

FILE: verif/tb_top.sv
module tb_top;

	localparam int NUM_TAPS      = 64;
	localparam int SAMPLE_W      = 16;
	// Give the block comfortably more than the time a result takes before
	// touching the tap count register.
	localparam int SETTLE_CYCLES = 200;
	// Long output back-pressure: far longer than it takes to fill the
	// output register and the accumulator, so in_ready has to drop.
	localparam int HOLD_CYCLES   = 1500;
	// Longest correct stretch without a transfer is the hold above plus the time
	// a result takes; allow many times that.
	localparam int QUIET_LIMIT   = 20000;
	localparam int PHASE_ITEMS   = 100;

	typedef struct packed {
		logic                                func;
		logic [mfc_pkg::TAP_INDEX_W-1:0]     tap_index;
		logic signed [SAMPLE_W-1:0]          value;
	} corr_item_t;

	logic                                clk         = 1'b0;
	logic                                arst_n      = 1'b0;
	logic                                in_valid    = 1'b0;
	logic                                in_ready;
	logic                                func        = mfc_pkg::FUNC_LOAD;
	logic [mfc_pkg::TAP_INDEX_W-1:0]     tap_index   = '0;
	logic signed [SAMPLE_W-1:0]          value       = '0;
	logic                                out_valid;
	logic                                out_ready   = 1'b0;
	logic signed [mfc_pkg::SUM_W-1:0]    correlation_sum;
	logic                                cfg_wr_en   = 1'b0;
	logic [mfc_pkg::TAP_COUNT_W-1:0]     cfg_wr_data = '0;

	// Mirror of the correlator: taps, delay line (entry 0 newest), fill count
	logic signed [SAMPLE_W-1:0]      tap_mirror    [NUM_TAPS] = '{default: '0};
	logic signed [SAMPLE_W-1:0]      sample_mirror [NUM_TAPS] = '{default: '0};
	logic [mfc_pkg::TAP_COUNT_W-1:0] tap_count_mirror = mfc_pkg::TAP_COUNT_RESET;
	int unsigned                     samples_seen     = 0;

	logic signed [mfc_pkg::SUM_W-1:0] expected_sums [$];
	logic signed [mfc_pkg::SUM_W-1:0] oldest_sum;
	corr_item_t                       item_backlog  [$];
	corr_item_t                       head_item;

	bit steady        = 1'b0;   // suppress random idling on both sides
	int holds_asked   = 0;
	int holds_served  = 0;
	int hold_left     = 0;
	int mismatches    = 0;
	int quiet_cycles  = 0;

	matched_filter_correlator #(
		.NUM_TAPS     (NUM_TAPS),
		.SAMPLE_WIDTH (SAMPLE_W)
	) u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.func            (func),
		.tap_index       (tap_index),
		.value           (value),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.correlation_sum (correlation_sum),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Apply one accepted item to the mirror; queue the sum it produces, if any.
	task automatic correlate_item(input corr_item_t it);
		int unsigned win;
		longint      acc;
		if (it.func == mfc_pkg::FUNC_LOAD) begin
			tap_mirror[it.tap_index] = it.value;
		end else begin
			for (int j = NUM_TAPS - 1; j > 0; j--)
				sample_mirror[j] = sample_mirror[j - 1];
			sample_mirror[0] = it.value;
			// Zero counts as a one-tap window, anything past the array clamps.
			if (tap_count_mirror == 0)
				win = 1;
			else if (tap_count_mirror > NUM_TAPS)
				win = NUM_TAPS;
			else
				win = tap_count_mirror;
			if (samples_seen < win)
				samples_seen++;
			// Fill count may sit above a lowered window: results go on at once.
			if (samples_seen >= win) begin
				acc = 0;
				// Tap 0 meets the oldest sample of the window.
				for (int j = 0; j < win; j++)
					acc += longint'(tap_mirror[j]) * longint'(sample_mirror[win - 1 - j]);
				expected_sums.insert(expected_sums.size(), acc[mfc_pkg::SUM_W-1:0]);
			end
		end
	endtask

	// Bias toward the field extremes and tiny values; the rest is full range.
	function automatic logic signed [SAMPLE_W-1:0] pick_value();
		case ($urandom_range(7))
			0: pick_value = 16'sh8000;
			1: pick_value = 16'sh7fff;
			2: pick_value = SAMPLE_W'($urandom_range(8)) - SAMPLE_W'(4);
			default: pick_value = SAMPLE_W'($urandom);
		endcase
	endfunction

	task automatic push_item(input logic f, input int idx, input int v);
		corr_item_t it;
		it.func      = f;
		it.tap_index = mfc_pkg::TAP_INDEX_W'(idx);
		it.value     = SAMPLE_W'(v);
		item_backlog.insert(item_backlog.size(), it);
	endtask

	task automatic random_phase(input int count, input int load_pct);
		corr_item_t it;
		repeat (count) begin
			it.func      = ($urandom_range(99) < load_pct) ? mfc_pkg::FUNC_LOAD
			                                               : mfc_pkg::FUNC_SAMPLE;
			it.tap_index = mfc_pkg::TAP_INDEX_W'($urandom);
			it.value     = pick_value();
			item_backlog.insert(item_backlog.size(), it);
		end
	endtask

	// Wait until every item is taken and every sum has come out,
	// then give a trailing load or rotate-home time to finish.
	task automatic wait_idle();
		while (item_backlog.size() != 0 || in_valid || expected_sums.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_tap_count(input logic [mfc_pkg::TAP_COUNT_W-1:0] count);
		@(posedge clk);
		cfg_wr_en        <= 1'b1;
		cfg_wr_data      <= count;
		tap_count_mirror  = count;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Sender: advance to the next item once the current one transfers, or
	// drop valid when no item is queued or, when not running steady, at random.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_ready) begin
			if (item_backlog.size() != 0 && (steady || $urandom_range(99) >= 10)) begin
				head_item  = item_backlog.pop_front();
				in_valid  <= 1'b1;
				func      <= head_item.func;
				tap_index <= head_item.tap_index;
				value     <= head_item.value;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, plus long hold-offs on request.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (holds_served != holds_asked) begin
			out_ready    <= 1'b0;
			hold_left    <= HOLD_CYCLES;
			holds_served <= holds_served + 1;
		end else begin
			out_ready <= steady || $urandom_range(99) >= 10;
		end
	end

	// Input side: every transfer goes through the mirror.
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			correlate_item('{func: func, tap_index: tap_index, value: value});
	end

	// Output side: compare each transferred sum with the oldest one queued.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_sums.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected correlation sum %0d", correlation_sum);
				mismatches++;
			end else begin
				oldest_sum = expected_sums.pop_front();
				if (correlation_sum !== oldest_sum) begin
					if (mismatches < 10)
						$display("correlation sum mismatch: expected %0d, got %0d",
							oldest_sum, correlation_sum);
					mismatches++;
				end
			end
		end
	end

	// Watchdog: end the run if nothing transfers on either side for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Zero tap count acts as a single-tap window: every sample gives tap0*sample.
		set_tap_count(7'd0);
		@(negedge clk);
		push_item(mfc_pkg::FUNC_LOAD, 0, -32768);
		push_item(mfc_pkg::FUNC_LOAD, 63, 32767);
		push_item(mfc_pkg::FUNC_LOAD, 1, -1);
		push_item(mfc_pkg::FUNC_SAMPLE, 0, -32768);
		push_item(mfc_pkg::FUNC_SAMPLE, 63, 32767);
		push_item(mfc_pkg::FUNC_SAMPLE, 21, 0);
		push_item(mfc_pkg::FUNC_SAMPLE, 42, -1);
		push_item(mfc_pkg::FUNC_SAMPLE, 0, 1);
		push_item(mfc_pkg::FUNC_LOAD, 0, 32767);
		push_item(mfc_pkg::FUNC_SAMPLE, 0, -32768);
		push_item(mfc_pkg::FUNC_SAMPLE, 0, 32767);
		wait_idle();

		// Raise the window mid-stream: two more samples before sums resume.
		set_tap_count(7'd3);
		@(negedge clk);
		push_item(mfc_pkg::FUNC_LOAD, 2, -32768);
		push_item(mfc_pkg::FUNC_SAMPLE, 5, 32767);
		push_item(mfc_pkg::FUNC_SAMPLE, 5, -32768);
		push_item(mfc_pkg::FUNC_SAMPLE, 5, 1);
		push_item(mfc_pkg::FUNC_SAMPLE, 5, -32768);
		wait_idle();

		// Lower the window: sums continue on the very next sample.
		set_tap_count(7'd2);
		@(negedge clk);
		push_item(mfc_pkg::FUNC_SAMPLE, 0, 32767);
		push_item(mfc_pkg::FUNC_SAMPLE, 0, -32768);
		push_item(mfc_pkg::FUNC_SAMPLE, 0, -32768);
		wait_idle();

		// Out-of-range count clamps to the full window. Drive the sum to its
		// extremes with every tap at full negative scale, and hold the output
		// off long enough that the block backs up and stalls its input.
		set_tap_count(7'd127);
		@(negedge clk);
		for (int i = 0; i < NUM_TAPS; i++)
			push_item(mfc_pkg::FUNC_LOAD, i, -32768);
		repeat (PHASE_ITEMS)
			push_item(mfc_pkg::FUNC_SAMPLE, $urandom_range(63),
				($urandom_range(4) == 0) ? 32767 : -32768);
		holds_asked++;
		wait_idle();

		// Random traffic over a spread of window lengths, extremes included.
		for (int p = 0; p < 8; p++) begin
			case (p)
				0: set_tap_count(7'd1);
				1: set_tap_count(7'd64);
				2: set_tap_count(7'd0);
				3: set_tap_count(7'd127);
				4: set_tap_count(7'd100);
				default: set_tap_count(mfc_pkg::TAP_COUNT_W'($urandom_range(63, 2)));
			endcase
			@(negedge clk);
			steady = (p == 5);
			random_phase(PHASE_ITEMS, 20);
			wait_idle();
			steady = 1'b0;
		end

		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

FILE: filelist.f
rtl/mfc_pkg.sv
rtl/mfc_cell.sv
rtl/mfc_mac.sv
rtl/matched_filter_correlator.sv
verif/tb_top.sv
